// ----- hw/rtl/pdp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdp_pkg
// Shared widths, codes and inter-module types for the position difference
// projection block.
// ----------------------------------------------------------------------------
package pdp_pkg;

  // Field widths of the input and result words
  localparam int VALUE_W    = 32;
  localparam int OPCODE_W   = 2;
  localparam int ROW_IDX_W  = 8;
  localparam int DC_W       = 4;
  localparam int COL_W      = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int ROWS_REG_W = 7;
  localparam int DIMS_REG_W = 3;
  localparam int COLS_REG_W = 5;

  // One multiply lane per target coordinate field
  localparam int NUM_LANES  = 4;

  // Arithmetic widths: exact difference, exact product, Q33.16 terms, sums
  localparam int DIFF_W     = VALUE_W + 1;
  localparam int PROD_W     = DIFF_W + VALUE_W;
  localparam int FRAC_SHIFT = 16;
  localparam int TERM_W     = PROD_W - FRAC_SHIFT;
  localparam int PSUM_W     = TERM_W + 1;
  localparam int TOTAL_W    = PSUM_W + 1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD_POINT  = 2'd0,
    OP_LOAD_MATRIX = 2'd1,
    OP_COMPUTE     = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_ROWS = 2'd0,
    CFG_NUM_DIMS = 2'd1,
    CFG_NUM_COLS = 2'd2
  } cfg_idx_e;

  typedef logic [VALUE_W-1:0] value_t;

  // One column beat after the store reads
  typedef struct packed {
    logic                          valid;
    logic [COL_W-1:0]              column;
    logic                          last;
    logic [NUM_LANES-1:0]          lane_en;
    value_t [NUM_LANES-1:0]        target;
    value_t [NUM_LANES-1:0]        point;
    value_t [NUM_LANES-1:0]        coef;
  } beat_t;

  // Finished result word
  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] column;
    value_t           value;
    logic             last;
  } result_t;

endpackage

// ----- hw/rtl/pdp_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdp_in_if
// Input channel: load and compute words with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pdp_in_if;
  import pdp_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic [ROW_IDX_W-1:0]       row_index;
  logic [DC_W-1:0]            dim_or_col;
  logic signed [VALUE_W-1:0]  load_value;
  logic signed [VALUE_W-1:0]  target_x0;
  logic signed [VALUE_W-1:0]  target_x1;
  logic signed [VALUE_W-1:0]  target_x2;
  logic signed [VALUE_W-1:0]  target_x3;

  modport source (
    output valid, opcode, row_index, dim_or_col, load_value,
    output target_x0, target_x1, target_x2, target_x3,
    input  ready
  );

  modport sink (
    input  valid, opcode, row_index, dim_or_col, load_value,
    input  target_x0, target_x1, target_x2, target_x3,
    output ready
  );

endinterface

// ----- hw/rtl/pdp_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdp_out_if
// Output channel: one projected column result per word.
// ----------------------------------------------------------------------------
interface pdp_out_if;
  import pdp_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [COL_W-1:0]           column;
  logic signed [VALUE_W-1:0]  result_value;
  logic                       is_last;

  modport source (
    output valid, column, result_value, is_last,
    input  ready
  );

  modport sink (
    input  valid, column, result_value, is_last,
    output ready
  );

endinterface

// ----- hw/rtl/pdp_arith.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdp_arith
// Four-stage arithmetic pipe: difference, multiply, floor shift with pair
// sums, final sum with saturation into the output register.
// ----------------------------------------------------------------------------
module pdp_arith (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  pdp_pkg::beat_t   beat_i,
  output pdp_pkg::result_t res_o
);
  import pdp_pkg::*;

  localparam int NUM_PAIRS = NUM_LANES / 2;

  // stage A: differences
  logic                            a_valid_q;
  logic [COL_W-1:0]                a_col_q;
  logic                            a_last_q;
  logic [NUM_LANES-1:0]            a_en_q;
  logic signed [DIFF_W-1:0]        a_diff_q [NUM_LANES];
  logic signed [VALUE_W-1:0]       a_coef_q [NUM_LANES];

  // stage B: products
  logic                            b_valid_q;
  logic [COL_W-1:0]                b_col_q;
  logic                            b_last_q;
  logic signed [PROD_W-1:0]        b_prod_q [NUM_LANES];
  logic signed [PROD_W-1:0]        b_prod_d [NUM_LANES];

  // stage C: pair sums of the shifted terms
  logic                            c_valid_q;
  logic [COL_W-1:0]                c_col_q;
  logic                            c_last_q;
  logic signed [PSUM_W-1:0]        c_psum_q [NUM_PAIRS];
  logic signed [PSUM_W-1:0]        c_psum_d [NUM_PAIRS];
  logic signed [TERM_W-1:0]        term [NUM_LANES];

  // stage D: output register
  logic                            o_valid_q;
  logic [COL_W-1:0]                o_col_q;
  logic                            o_last_q;
  value_t                          o_value_q;
  value_t                          o_value_d;
  logic signed [TOTAL_W-1:0]       total;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= beat_i.valid;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      o_valid_q <= c_valid_q;
    end
  end

  // products, masked for lanes beyond the active dimensions
  always_comb begin
    for (int d = 0; d < NUM_LANES; d++) begin
      if (a_en_q[d]) begin
        b_prod_d[d] = a_diff_q[d] * a_coef_q[d];
      end else begin
        b_prod_d[d] = '0;
      end
    end
  end

  // arithmetic shift right is the floor of the Q33.32 to Q33.16 step
  always_comb begin
    for (int d = 0; d < NUM_LANES; d++) begin
      term[d] = b_prod_q[d][PROD_W-1:FRAC_SHIFT];
    end
    for (int p = 0; p < NUM_PAIRS; p++) begin
      c_psum_d[p] = PSUM_W'(term[2*p]) + PSUM_W'(term[2*p+1]);
    end
  end

  // final sum and clamp to the 32-bit signed range
  always_comb begin
    total = TOTAL_W'(c_psum_q[0]) + TOTAL_W'(c_psum_q[1]);
    if (total > TOTAL_W'(64'sh7FFF_FFFF)) begin
      o_value_d = 32'h7FFF_FFFF;
    end else if (total < -TOTAL_W'(64'sh8000_0000)) begin
      o_value_d = 32'h8000_0000;
    end else begin
      o_value_d = total[VALUE_W-1:0];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_col_q  <= beat_i.column;
      a_last_q <= beat_i.last;
      a_en_q   <= beat_i.lane_en;
      for (int d = 0; d < NUM_LANES; d++) begin
        a_diff_q[d] <= $signed({beat_i.target[d][VALUE_W-1], beat_i.target[d]})
                     - $signed({beat_i.point[d][VALUE_W-1], beat_i.point[d]});
        a_coef_q[d] <= $signed(beat_i.coef[d]);
        b_prod_q[d] <= b_prod_d[d];
      end
      b_col_q  <= a_col_q;
      b_last_q <= a_last_q;
      c_col_q  <= b_col_q;
      c_last_q <= b_last_q;
      for (int p = 0; p < NUM_PAIRS; p++) begin
        c_psum_q[p] <= c_psum_d[p];
      end
      o_col_q   <= c_col_q;
      o_last_q  <= c_last_q;
      o_value_q <= o_value_d;
    end
  end

  assign res_o.valid  = o_valid_q;
  assign res_o.column = o_col_q;
  assign res_o.value  = o_value_q;
  assign res_o.last   = o_last_q;

endmodule

// ----- hw/rtl/position_difference_projection.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_difference_projection
// Projects the difference between a target point and a stored reference
// point through a stored matrix, one saturated Q16.16 result per column.
// ----------------------------------------------------------------------------
// Load words (opcode 0/1) write one point coordinate or one matrix entry. A
// compute word (opcode 2) for a row below num_rows holds the input until the
// last of its num_cols columns (registers clamped to 1..MAX_*) issues. While
// the output does not stall, a column sequencer issues one column per cycle
// and results leave at one word per cycle, as each column reads all of its
// num_dims matrix entries at once. The matrix is held in ceil(MAX_DIMS/2)
// identical copies with two read ports each and the points in one bank per
// dimension, which is what lets every dimension be read in the same cycle.
// Compute words for rows at or above num_rows and opcode 3 produce nothing.
// Stores are not cleared by reset; an entry must be loaded before a compute
// word uses it.
// ----------------------------------------------------------------------------
module position_difference_projection #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_DIMS = 4,
  parameter int MAX_COLS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pdp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pdp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  pdp_in_if.sink                             in_i,
  pdp_out_if.source                          out_o
);
  import pdp_pkg::*;

  localparam int PT_AW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int MX_DEPTH   = MAX_ROWS * MAX_DIMS * MAX_COLS;
  localparam int MX_AW      = (MX_DEPTH > 1) ? $clog2(MX_DEPTH) : 1;
  localparam int ROWS_W     = $clog2(MAX_ROWS + 1);
  localparam int NUM_COPIES = (MAX_DIMS + 1) / 2;

  // configuration registers
  logic [ROWS_REG_W-1:0] num_rows_q;
  logic [DIMS_REG_W-1:0] num_dims_q;
  logic [COLS_REG_W-1:0] num_cols_q;

  // clamped settings
  logic [ROWS_W-1:0]     rows_c;
  logic [DIMS_REG_W-1:0] dims_c;
  logic [COLS_REG_W-1:0] cols_c;

  // handshake and decode
  logic                  adv;
  logic                  issue;
  logic                  seq_last;
  logic                  in_ready;
  logic                  in_acc;
  logic                  pt_we;
  logic                  mx_we;
  logic                  start;
  logic [PT_AW-1:0]      pt_waddr;
  logic [MX_AW-1:0]      mx_waddr;
  logic [MX_AW-1:0]      base_d [MAX_DIMS];
  logic [NUM_LANES-1:0]  lane_en_d;

  // column sequencer
  logic                  busy_q;
  logic [COL_W-1:0]      k_q;
  logic [COLS_REG_W-1:0] cols_q;
  logic [NUM_LANES-1:0]  lane_en_q;
  logic [PT_AW-1:0]      row_q;
  logic [MX_AW-1:0]      base_q [MAX_DIMS];
  value_t                target_q [NUM_LANES];
  logic [MX_AW-1:0]      mx_raddr [MAX_DIMS];

  // read stage
  value_t                pt_rd_q [MAX_DIMS];
  value_t                mx_rd_q [MAX_DIMS];
  logic                  s1_valid_q;
  logic [COL_W-1:0]      s1_col_q;
  logic                  s1_last_q;
  logic [NUM_LANES-1:0]  s1_lane_en_q;
  value_t                s1_target_q [NUM_LANES];

  beat_t                 beat;
  result_t               res;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= ROWS_REG_W'(1);
      num_dims_q <= DIMS_REG_W'(1);
      num_cols_q <= COLS_REG_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUM_ROWS: num_rows_q <= cfg_data_i[ROWS_REG_W-1:0];
        CFG_NUM_DIMS: num_dims_q <= cfg_data_i[DIMS_REG_W-1:0];
        CFG_NUM_COLS: num_cols_q <= cfg_data_i[COLS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp each register to 1..MAX_*
  always_comb begin
    if (num_rows_q == '0) begin
      rows_c = ROWS_W'(1);
    end else if (32'(num_rows_q) > 32'(MAX_ROWS)) begin
      rows_c = ROWS_W'(MAX_ROWS);
    end else begin
      rows_c = ROWS_W'(num_rows_q);
    end
    if (num_dims_q == '0) begin
      dims_c = DIMS_REG_W'(1);
    end else if (32'(num_dims_q) > 32'(MAX_DIMS)) begin
      dims_c = DIMS_REG_W'(MAX_DIMS);
    end else begin
      dims_c = num_dims_q;
    end
    if (num_cols_q == '0) begin
      cols_c = COLS_REG_W'(1);
    end else if (32'(num_cols_q) > 32'(MAX_COLS)) begin
      cols_c = COLS_REG_W'(MAX_COLS);
    end else begin
      cols_c = num_cols_q;
    end
  end

  // whole pipe moves unless a finished word is waiting
  assign adv      = !res.valid || out_o.ready;
  assign seq_last = (COLS_REG_W'(k_q) + COLS_REG_W'(1)) == cols_q;
  assign issue    = busy_q && adv;
  assign in_ready = !busy_q || (adv && seq_last);
  assign in_acc   = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // input word decode
  always_comb begin
    pt_we = 1'b0;
    mx_we = 1'b0;
    start = 1'b0;
    if (in_acc) begin
      unique case (op_e'(in_i.opcode))
        OP_LOAD_POINT: begin
          pt_we = (32'(in_i.row_index) < 32'(MAX_ROWS))
               && (32'(in_i.dim_or_col) < 32'(MAX_DIMS));
        end
        OP_LOAD_MATRIX: begin
          mx_we = (32'(in_i.row_index) < 32'(MAX_ROWS * MAX_DIMS))
               && (32'(in_i.dim_or_col) < 32'(MAX_COLS));
        end
        OP_COMPUTE: begin
          start = 32'(in_i.row_index) < 32'(rows_c);
        end
        default: ;
      endcase
    end
  end

  assign pt_waddr = PT_AW'(in_i.row_index);
  assign mx_waddr = MX_AW'(32'(in_i.row_index) * 32'(MAX_COLS) + 32'(in_i.dim_or_col));

  // matrix row of dimension d is row + d * rows
  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      base_d[d] = MX_AW'((32'(in_i.row_index) + 32'(d) * 32'(rows_c)) * 32'(MAX_COLS));
    end
    for (int d = 0; d < NUM_LANES; d++) begin
      lane_en_d[d] = 32'(d) < 32'(dims_c);
    end
  end

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
    end else if (start) begin
      busy_q <= 1'b1;
      k_q    <= '0;
    end else if (issue) begin
      if (seq_last) begin
        busy_q <= 1'b0;
      end
      k_q <= k_q + COL_W'(1);
    end
  end

  // sequencer payload, captured with the compute word
  always_ff @(posedge clk_i) begin
    if (start) begin
      row_q       <= pt_waddr;
      cols_q      <= cols_c;
      lane_en_q   <= lane_en_d;
      base_q      <= base_d;
      target_q[0] <= in_i.target_x0;
      target_q[1] <= in_i.target_x1;
      target_q[2] <= in_i.target_x2;
      target_q[3] <= in_i.target_x3;
    end
  end

  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      mx_raddr[d] = base_q[d] + MX_AW'(k_q);
    end
  end

  // point store, one bank per dimension
  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_pt_bank
    value_t pt_mem [MAX_ROWS];

    always_ff @(posedge clk_i) begin
      if (pt_we && (in_i.dim_or_col == DC_W'(d))) begin
        pt_mem[pt_waddr] <= in_i.load_value;
      end
      if (adv) begin
        pt_rd_q[d] <= pt_mem[row_q];
      end
    end
  end

  // matrix store copies, two read ports each
  for (genvar c = 0; c < NUM_COPIES; c++) begin : g_mx_copy
    value_t mx_mem [MX_DEPTH];

    always_ff @(posedge clk_i) begin
      if (mx_we) begin
        mx_mem[mx_waddr] <= in_i.load_value;
      end
      if (adv) begin
        mx_rd_q[2*c] <= mx_mem[mx_raddr[2*c]];
      end
    end

    if (2 * c + 1 < MAX_DIMS) begin : g_port_b
      always_ff @(posedge clk_i) begin
        if (adv) begin
          mx_rd_q[2*c+1] <= mx_mem[mx_raddr[2*c+1]];
        end
      end
    end
  end

  // read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_col_q     <= k_q;
      s1_last_q    <= seq_last;
      s1_lane_en_q <= lane_en_q;
      s1_target_q  <= target_q;
    end
  end

  // beat into the arithmetic pipe; point and coefficient of lanes past MAX_DIMS stay zero
  assign beat.valid   = s1_valid_q;
  assign beat.column  = s1_col_q;
  assign beat.last    = s1_last_q;
  assign beat.lane_en = s1_lane_en_q;

  for (genvar d = 0; d < NUM_LANES; d++) begin : g_lane
    assign beat.target[d] = s1_target_q[d];
    if (d < MAX_DIMS) begin : g_used
      assign beat.point[d] = pt_rd_q[d];
      assign beat.coef[d]  = mx_rd_q[d];
    end else begin : g_unused
      assign beat.point[d] = '0;
      assign beat.coef[d]  = '0;
    end
  end

  pdp_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .beat_i (beat),
    .res_o  (res)
  );

  assign out_o.valid        = res.valid;
  assign out_o.column       = res.column;
  assign out_o.result_value = res.value;
  assign out_o.is_last      = res.last;

  // column counter stays inside the active column range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (COLS_REG_W'(k_q) < cols_q))
    else $error("column counter past column count");

  // a non-final issue steps to the next column and stays busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && !seq_last) |=> (busy_q && (k_q == $past(k_q) + COL_W'(1))))
    else $error("sequencer did not step to next column");

  // an active compute always has dimension zero enabled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> lane_en_q[0])
    else $error("compute active with no dimension lane");

  // a stalled read-stage word is kept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |=> s1_valid_q)
    else $error("read-stage word lost during stall");

endmodule
